// ===== hw/rtl/srpi_pkg.sv =====
// Package: shared widths, sector table and stage types for the segment/16-gon intersector.
`default_nettype none
package srpi_pkg;
  localparam int COORD_FRAC_BITS = 16;
  localparam int ANGLE_FRAC_BITS = 14;
  localparam int NSEC = 16;
  localparam int ONE_A = 1 << ANGLE_FRAC_BITS;
  localparam int TAB_C1 = ((92388 << ANGLE_FRAC_BITS) + 50000) / 100000;
  localparam int TAB_C2 = ((70711 << ANGLE_FRAC_BITS) + 50000) / 100000;
  localparam int TAB_C3 = ((38268 << ANGLE_FRAC_BITS) + 50000) / 100000;
  localparam int TW = ANGLE_FRAC_BITS + 2;   // signed table entry width
  localparam int LW = TW + 8;                // r * table
  localparam int RW = LW + 16 + 1;           // rotated offset
  localparam int SH = 2 * ANGLE_FRAC_BITS - COORD_FRAC_BITS;
  localparam int VW = 34;                    // vertex coordinate width
  localparam int DW = 36;                    // difference width
  localparam int PW = 2 * DW;                // product width
  localparam int NW = PW + 1;                // cross-product difference width
  localparam int IN_W = 384;
  localparam int OUT_W = 24;

  typedef logic signed [TW-1:0] tab_t;
  typedef logic signed [VW-1:0] vtx_t;
  typedef logic signed [DW-1:0] dif_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [NW-1:0] num_t;
  typedef logic [16:0] frac_t;

  function automatic tab_t sec_cos(input logic [3:0] k);
    tab_t v;
    unique case (k)
      4'd0: v = tab_t'(ONE_A);
      4'd1, 4'd15: v = tab_t'(TAB_C1);
      4'd2, 4'd14: v = tab_t'(TAB_C2);
      4'd3, 4'd13: v = tab_t'(TAB_C3);
      4'd4, 4'd12: v = '0;
      4'd5, 4'd11: v = -tab_t'(TAB_C3);
      4'd6, 4'd10: v = -tab_t'(TAB_C2);
      4'd7, 4'd9: v = -tab_t'(TAB_C1);
      default: v = -tab_t'(ONE_A);
    endcase
    return v;
  endfunction

  // Rotated offset to coordinate format, floor on the dropped bits.
  function automatic vtx_t to_coord(input logic signed [RW-1:0] v);
    logic signed [RW-1:0] s;
    s = v >>> SH;
    return vtx_t'(s);
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/srpi_div.sv =====
// Module: pipelined restoring divider, 16 fraction bits, one bit per stage.
`default_nettype none
module srpi_div (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire logic in_ok,
  input  wire logic in_one,
  input  wire srpi_pkg::num_t in_num,
  input  wire srpi_pkg::num_t in_den,
  output logic out_ok,
  output srpi_pkg::frac_t out_q
);
  logic [srpi_pkg::NW:0] rem_r [1:16];
  srpi_pkg::num_t den_r [1:16];
  logic [15:0] q_r [1:16];
  logic ok_r [1:16];
  logic one_r [1:16];

  for (genvar i = 0; i < 16; i++) begin : g_st
    logic [srpi_pkg::NW:0] rem_s;
    srpi_pkg::num_t den_s;
    logic [15:0] q_s;
    logic ok_s, one_s;
    logic [srpi_pkg::NW:0] sh;
    logic ge;
    if (i == 0) begin : g_head
      assign rem_s = {1'b0, in_num};
      assign den_s = in_den;
      assign q_s = '0;
      assign ok_s = in_ok;
      assign one_s = in_one;
    end else begin : g_tail
      assign rem_s = rem_r[i];
      assign den_s = den_r[i];
      assign q_s = q_r[i];
      assign ok_s = ok_r[i];
      assign one_s = one_r[i];
    end
    always_comb begin
      sh = {rem_s[srpi_pkg::NW-1:0], 1'b0};
      ge = sh >= {1'b0, den_s};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ok_r[i+1] <= 1'b0;
      end else if (en) begin
        ok_r[i+1] <= ok_s;
      end
      if (en) begin
        rem_r[i+1] <= ge ? sh - {1'b0, den_s} : sh;
        den_r[i+1] <= den_s;
        q_r[i+1] <= {q_s[14:0], ge};
        one_r[i+1] <= one_s;
      end
    end
  end

  assign out_ok = ok_r[16];
  assign out_q = one_r[16] ? 17'h10000 : {1'b0, q_r[16]};
endmodule
`default_nettype wire

// ===== hw/rtl/segment_radial_polygon_intersect.sv =====
// Module: segment versus radial 16-gon intersection, fully pipelined.
// Channel | dir | payload
// in_     | in  | radii, centre, facing, segment (384-bit tdata)
// out_    | out | hit, hit_fraction (24-bit tdata)
// One item per cycle while the output is not stalled, through the vertex,
// cross-product, compare, divide and min-tree stages.
// The whole pipe advances when the output register is empty or taken.
// Reset clears the valid bits only.
`default_nettype none
module segment_radial_polygon_intersect (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic in_tready,
  // radii_sectors_0_to_7, radii_sectors_8_to_15, centre_x, centre_y,
  // facing_cos, facing_sin, seg_start_x, seg_start_y, seg_end_x, seg_end_y
  input  wire logic [srpi_pkg::IN_W-1:0] in_tdata,
  output logic out_tvalid,
  input  wire logic out_tready,
  // hit, hit_fraction, zero fill
  output logic [srpi_pkg::OUT_W-1:0] out_tdata
);
  localparam int NS = srpi_pkg::NSEC;
  logic en;
  assign en = !out_tvalid || out_tready;
  assign in_tready = en;

  // stage 1: local offsets
  logic v1_r;
  logic signed [srpi_pkg::LW-1:0] lx1_r [NS], ly1_r [NS];
  logic signed [31:0] cx1_r, cy1_r, sx1_r, sy1_r, ex1_r, ey1_r;
  logic signed [15:0] ox1_r, oy1_r;
  // stage 2: rotation products
  logic v2_r;
  logic signed [srpi_pkg::RW-1:0] p1_r [NS], p2_r [NS], p3_r [NS], p4_r [NS];
  logic signed [31:0] cx2_r, cy2_r, sx2_r, sy2_r, ex2_r, ey2_r;
  // stage 3: vertices
  logic v3_r;
  srpi_pkg::vtx_t px3_r [NS], py3_r [NS];
  logic signed [31:0] sx3_r, sy3_r, ex3_r, ey3_r;
  // stage 4: differences
  logic v4_r;
  srpi_pkg::dif_t e1x4_r [NS], e1y4_r [NS], ofx4_r [NS], ofy4_r [NS];
  srpi_pkg::dif_t rdx4_r, rdy4_r;
  // stage 5: products
  logic v5_r;
  srpi_pkg::prod_t a5_r [NS], b5_r [NS], c5_r [NS], d5_r [NS], f5_r [NS], g5_r [NS];
  // stage 6: numerators and denominator, sign-normalized
  logic v6_r;
  srpi_pkg::num_t den6_r [NS], nt6_r [NS], nu6_r [NS];
  // stage 7: acceptance
  logic v7_r;
  logic ok7_r [NS], one7_r [NS];
  srpi_pkg::num_t nt7_r [NS], den7_r [NS];

  logic dok [NS];
  srpi_pkg::frac_t dq [NS];
  logic dv_r [1:16];

  for (genvar k = 0; k < NS; k++) begin : g_sec
    localparam int J = (k + 1) % NS;
    always_ff @(posedge clk) begin
      if (en) begin
        lx1_r[k] <= $signed({1'b0, in_tdata[8*k +: 8]}) *
                    srpi_pkg::sec_cos(4'(k));
        ly1_r[k] <= $signed({1'b0, in_tdata[8*k +: 8]}) *
                    srpi_pkg::sec_cos(4'((k + 12) % NS));
        p1_r[k] <= lx1_r[k] * ox1_r;
        p2_r[k] <= ly1_r[k] * oy1_r;
        p3_r[k] <= lx1_r[k] * oy1_r;
        p4_r[k] <= ly1_r[k] * ox1_r;
        px3_r[k] <= srpi_pkg::vtx_t'(cx2_r) + srpi_pkg::to_coord(p1_r[k] - p2_r[k]);
        py3_r[k] <= srpi_pkg::vtx_t'(cy2_r) + srpi_pkg::to_coord(p3_r[k] + p4_r[k]);
        e1x4_r[k] <= srpi_pkg::dif_t'(px3_r[J]) - srpi_pkg::dif_t'(px3_r[k]);
        e1y4_r[k] <= srpi_pkg::dif_t'(py3_r[J]) - srpi_pkg::dif_t'(py3_r[k]);
        ofx4_r[k] <= srpi_pkg::dif_t'(px3_r[k]) - srpi_pkg::dif_t'(sx3_r);
        ofy4_r[k] <= srpi_pkg::dif_t'(py3_r[k]) - srpi_pkg::dif_t'(sy3_r);
        a5_r[k] <= rdx4_r * e1y4_r[k];
        b5_r[k] <= rdy4_r * e1x4_r[k];
        c5_r[k] <= ofx4_r[k] * e1y4_r[k];
        d5_r[k] <= ofy4_r[k] * e1x4_r[k];
        f5_r[k] <= ofx4_r[k] * rdy4_r;
        g5_r[k] <= ofy4_r[k] * rdx4_r;
      end
    end

    srpi_pkg::num_t den_n, nt_n, nu_n;
    always_comb begin
      den_n = srpi_pkg::num_t'(a5_r[k]) - srpi_pkg::num_t'(b5_r[k]);
      nt_n = srpi_pkg::num_t'(c5_r[k]) - srpi_pkg::num_t'(d5_r[k]);
      nu_n = srpi_pkg::num_t'(f5_r[k]) - srpi_pkg::num_t'(g5_r[k]);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        den6_r[k] <= den_n[srpi_pkg::NW-1] ? -den_n : den_n;
        nt6_r[k] <= den_n[srpi_pkg::NW-1] ? -nt_n : nt_n;
        nu6_r[k] <= den_n[srpi_pkg::NW-1] ? -nu_n : nu_n;
        ok7_r[k] <= (den6_r[k] != '0) && !nt6_r[k][srpi_pkg::NW-1] &&
                    !nu6_r[k][srpi_pkg::NW-1] && (den6_r[k] >= nt6_r[k]) &&
                    (den6_r[k] >= nu6_r[k]);
        one7_r[k] <= nt6_r[k] == den6_r[k];
        nt7_r[k] <= nt6_r[k];
        den7_r[k] <= den6_r[k];
      end
    end

    srpi_div u_div (
      .clk(clk), .rst_n(rst_n), .en(en), .in_ok(ok7_r[k] && v7_r),
      .in_one(one7_r[k]), .in_num(nt7_r[k]), .in_den(den7_r[k]),
      .out_ok(dok[k]), .out_q(dq[k])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx1_r <= in_tdata[159:128];
      cy1_r <= in_tdata[191:160];
      ox1_r <= in_tdata[207:192];
      oy1_r <= in_tdata[223:208];
      sx1_r <= in_tdata[255:224];
      sy1_r <= in_tdata[287:256];
      ex1_r <= in_tdata[319:288];
      ey1_r <= in_tdata[351:320];
      cx2_r <= cx1_r; cy2_r <= cy1_r;
      sx2_r <= sx1_r; sy2_r <= sy1_r; ex2_r <= ex1_r; ey2_r <= ey1_r;
      sx3_r <= sx2_r; sy3_r <= sy2_r; ex3_r <= ex2_r; ey3_r <= ey2_r;
      rdx4_r <= srpi_pkg::dif_t'(ex3_r) - srpi_pkg::dif_t'(sx3_r);
      rdy4_r <= srpi_pkg::dif_t'(ey3_r) - srpi_pkg::dif_t'(sy3_r);
    end
  end

  // min tree: 16 -> 4 registered, 4 -> 1 at the output
  logic m_v_r;
  logic mok_r [4];
  srpi_pkg::frac_t mq_r [4];
  for (genvar g = 0; g < 4; g++) begin : g_min
    logic ok_n;
    srpi_pkg::frac_t q_n;
    always_comb begin
      ok_n = 1'b0;
      q_n = '0;
      for (int i = 0; i < 4; i++) begin
        if (dok[4*g+i] && (!ok_n || dq[4*g+i] < q_n)) begin
          ok_n = 1'b1;
          q_n = dq[4*g+i];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        mok_r[g] <= ok_n;
        mq_r[g] <= q_n;
      end
    end
  end

  logic hit_n;
  srpi_pkg::frac_t best_n;
  always_comb begin
    hit_n = 1'b0;
    best_n = '0;
    for (int i = 0; i < 4; i++) begin
      if (mok_r[i] && (!hit_n || mq_r[i] < best_n)) begin
        hit_n = 1'b1;
        best_n = mq_r[i];
      end
    end
  end

  for (genvar i = 1; i <= 16; i++) begin : g_dv
    logic prev;
    if (i == 1) begin : g_head
      assign prev = v7_r;
    end else begin : g_tail
      assign prev = dv_r[i-1];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[i] <= 1'b0;
      else if (en) dv_r[i] <= prev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      v5_r <= 1'b0; v6_r <= 1'b0; v7_r <= 1'b0; m_v_r <= 1'b0;
      out_tvalid <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
      v5_r <= v4_r; v6_r <= v5_r; v7_r <= v6_r; m_v_r <= dv_r[16];
      out_tvalid <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata <= {6'd0, best_n, hit_n};
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/srpi_checker.sv =====
// Module: port-level checks for the intersector, bound to the top level.
`default_nettype none
module srpi_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_tready,
  input wire logic out_tvalid,
  input wire logic out_tready,
  input wire logic [srpi_pkg::OUT_W-1:0] out_tdata
);
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[17:1] == 17'd0) else $error("miss with fraction");
  a_frac_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[17:1] <= 17'h10000) else $error("fraction range");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready)) else $error("ready mismatch");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("output dropped");
endmodule

bind segment_radial_polygon_intersect srpi_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata)
);
`default_nettype wire

// ===== bench/segment_radial_polygon_intersect_checker.sv =====
// Checker: predicts segment/16-gon hits from accepted inputs and compares the results.
`timescale 1ns / 1ps
module segment_radial_polygon_intersect_checker (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  input  logic in_tready,
  input  logic [srpi_pkg::IN_W-1:0] in_tdata,
  input  logic out_tvalid,
  input  logic out_tready,
  input  logic [srpi_pkg::OUT_W-1:0] out_tdata,
  output int   fail_count,
  output int   pending
);
  typedef logic signed [127:0] wide_t;
  typedef struct packed {
    logic            hit;
    srpi_pkg::frac_t frac;
  } crossing_t;

  crossing_t crossings_due[$];

  // Sector direction table in Q1.14; the sine of sector k is the cosine of sector k+12.
  function automatic longint sector_dir(input int k);
    case (k & 15)
      0:       return srpi_pkg::ONE_A;
      1, 15:   return srpi_pkg::TAB_C1;
      2, 14:   return srpi_pkg::TAB_C2;
      3, 13:   return srpi_pkg::TAB_C3;
      4, 12:   return 0;
      5, 11:   return -srpi_pkg::TAB_C3;
      6, 10:   return -srpi_pkg::TAB_C2;
      7, 9:    return -srpi_pkg::TAB_C1;
      default: return -srpi_pkg::ONE_A;
    endcase
  endfunction

  function automatic crossing_t first_crossing(input logic [srpi_pkg::IN_W-1:0] d);
    longint px[16], py[16];
    longint cx, cy, ox, oy, sx, sy, rdx, rdy, r, lx, ly, dx, dy;
    longint e1x, e1y, ofx, ofy;
    wide_t den, nt, nu, t;
    crossing_t res;
    int j;
    cx = longint'($signed(d[159:128]));
    cy = longint'($signed(d[191:160]));
    ox = longint'($signed(d[207:192]));
    oy = longint'($signed(d[223:208]));
    sx = longint'($signed(d[255:224]));
    sy = longint'($signed(d[287:256]));
    rdx = longint'($signed(d[319:288])) - sx;
    rdy = longint'($signed(d[351:320])) - sy;
    res = '0;
    for (int k = 0; k < 16; k++) begin
      r = longint'(d[8*k +: 8]);
      lx = r * sector_dir(k);
      ly = r * sector_dir(k + 12);
      dx = lx * ox - ly * oy;
      dy = lx * oy + ly * ox;
      px[k] = cx + (dx >>> srpi_pkg::SH);
      py[k] = cy + (dy >>> srpi_pkg::SH);
    end
    for (int k = 0; k < 16; k++) begin
      j = (k + 1) & 15;
      e1x = px[j] - px[k];
      e1y = py[j] - py[k];
      ofx = px[k] - sx;
      ofy = py[k] - sy;
      den = wide_t'(rdx) * wide_t'(e1y) - wide_t'(rdy) * wide_t'(e1x);
      nt  = wide_t'(ofx) * wide_t'(e1y) - wide_t'(ofy) * wide_t'(e1x);
      nu  = wide_t'(ofx) * wide_t'(rdy) - wide_t'(ofy) * wide_t'(rdx);
      if (den == 0) continue;
      if (den < 0) begin
        den = -den;
        nt = -nt;
        nu = -nu;
      end
      if (nt < 0 || nu < 0 || nt > den || nu > den) continue;
      t = (nt <<< 16) / den;
      if (!res.hit || srpi_pkg::frac_t'(t) < res.frac) begin
        res.hit = 1'b1;
        res.frac = srpi_pkg::frac_t'(t);
      end
    end
    return res;
  endfunction

  assign pending = crossings_due.size();

  always @(posedge clk) begin
    crossing_t want, got;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_tvalid && in_tready)
        crossings_due.push_back(first_crossing(in_tdata));
      if (out_tvalid && out_tready) begin
        got.hit = out_tdata[0];
        got.frac = out_tdata[17:1];
        if (crossings_due.size() == 0) begin
          $display("%0t: unexpected result hit=%0b frac=%0d", $time, got.hit, got.frac);
          fail_count <= fail_count + 1;
        end else begin
          want = crossings_due.pop_front();
          if (want.hit !== got.hit || want.frac !== got.frac) begin
            $display("%0t: mismatch expected hit=%0b frac=%0d, actual hit=%0b frac=%0d",
                     $time, want.hit, want.frac, got.hit, got.frac);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== bench/segment_radial_polygon_intersect_tb.sv =====
// Testbench top: drives segment queries, stalls the result side and reports the verdict.
`timescale 1ns / 1ps
module segment_radial_polygon_intersect_tb;
  localparam int RANDOM_QUERIES = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int ONE = 1 << srpi_pkg::COORD_FRAC_BITS;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [srpi_pkg::IN_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [srpi_pkg::OUT_W-1:0] out_tdata;
  int   fail_count;
  int   pending;
  bit   sending_done;
  int   accepted;

  segment_radial_polygon_intersect u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  segment_radial_polygon_intersect_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [srpi_pkg::IN_W-1:0] query(
    input logic [63:0] r_lo, input logic [63:0] r_hi,
    input logic [31:0] cx, input logic [31:0] cy,
    input logic [15:0] fc, input logic [15:0] fs,
    input logic [31:0] sx, input logic [31:0] sy,
    input logic [31:0] ex, input logic [31:0] ey);
    return {32'd0, ey, ex, sy, sx, fs, fc, cy, cx, r_hi, r_lo};
  endfunction

  function automatic logic [63:0] rand_radii();
    return {$urandom(), $urandom()};
  endfunction

  function automatic int offset_near(input int span);
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic send(input logic [srpi_pkg::IN_W-1:0] d);
    int gap;
    gap = (accepted % 97 < 20) ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
    accepted++;
  endtask

  // Result side: random stall per result, and one long hold-off to back up the pipe.
  initial begin
    int stall;
    int taken;
    out_tready = 1'b0;
    taken = 0;
    @(posedge rst_n);
    while (!sending_done || pending > 0) begin
      if (taken == 300) stall = 200;
      else if (taken % 113 < 25) stall = 0;
      else stall = $urandom_range(0, 7);
      if (stall > 0) begin
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
    end
  end

  initial begin
    int c, s, span, cx, cy, r;
    logic [63:0] rl, rh;
    in_tvalid = 1'b0;
    in_tdata = '0;
    sending_done = 1'b0;
    accepted = 0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: degenerate and full radii, axis facings, touches, extremes.
    send(query('0, '0, 0, 0, 16'sd16384, 0, -5 * ONE, 0, 5 * ONE, 0));
    send(query('1, '1, 0, 0, 16'sd16384, 0, -300 * ONE, 0, 300 * ONE, 0));
    send(query('1, '1, 0, 0, 0, 16'sd16384, 0, -300 * ONE, 0, 300 * ONE));
    send(query('1, '1, 0, 0, -16'sd16384, 0, 300 * ONE, 1, -300 * ONE, 7));
    send(query('1, '1, 0, 0, 0, -16'sd16384, 3, 300 * ONE, 5, -300 * ONE));
    // Start exactly on vertex 0, then end exactly on it.
    r = 10;
    rl = {8{8'(r)}};
    send(query(rl, rl, 0, 0, 16'sd16384, 0, r * ONE, 0, (r + 5) * ONE, 3 * ONE));
    send(query(rl, rl, 0, 0, 16'sd16384, 0, (r + 5) * ONE, 3 * ONE, r * ONE, 0));
    // Zero-length segment on the polygon.
    send(query(rl, rl, 0, 0, 16'sd16384, 0, r * ONE, 0, r * ONE, 0));
    // The same zero-length segment again, built as an XOR with an all-zero query.
    send(query(rl, rl, 0, 0, 16'sd16384, 0, r * ONE, 0, r * ONE, 0) ^
         query('0, '0, 0, 0, 0, 0, 0, 0, 0, 0));
    send(query('1, '1, 32'h7fffffff, 32'h7fffffff, 16'sd16384, 16'sd16384,
               32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff));
    send(query('1, '1, 32'h80000000, 32'h80000000, -16'sd16384, -16'sd16384,
               32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff));
    send(query('1, '1, 0, 0, 16'sd16384, 16'sd16384, -400 * ONE, 0, 400 * ONE, 0));
    send(query('1, '1, 0, 0, -16'sd16384, 16'sd16384, 0, 0, 400 * ONE, 1));
    send(query({$urandom(), $urandom()}, '0, 0, 0, 16'sd11585, 16'sd11585,
               -50 * ONE, -70 * ONE, 80 * ONE, 60 * ONE));

    repeat (RANDOM_QUERIES) begin
      c = $signed($urandom_range(0, 32768)) - 16384;
      s = int'($sqrt(16384.0 * 16384.0 - real'(c) * real'(c)));
      if ($urandom_range(0, 1)) s = -s;
      rl = rand_radii();
      rh = rand_radii();
      case ($urandom_range(0, 9))
        0, 1: begin
          send(query(rl, rh, $urandom(), $urandom(), 16'(c), 16'(s),
                     $urandom(), $urandom(), $urandom(), $urandom()));
        end
        2: begin
          // Odd facings, sparse radii and zero-length or axis segments.
          rl &= {$urandom(), $urandom()};
          cx = offset_near(20 * ONE);
          cy = offset_near(20 * ONE);
          span = offset_near(300 * ONE);
          send(query(rl, rh & rand_radii(), cx, cy,
                     16'($signed($urandom_range(0, 32768)) - 16384),
                     16'($signed($urandom_range(0, 32768)) - 16384),
                     cx + span, cy, cx + ($urandom_range(0, 1) ? span : -span),
                     cy + ($urandom_range(0, 1) ? 0 : offset_near(300 * ONE))));
        end
        default: begin
          // Segment around the body so most queries hit.
          cx = offset_near(16 * ONE);
          cy = offset_near(16 * ONE);
          span = ($urandom_range(0, 3) == 0) ? 40 * ONE : 400 * ONE;
          send(query(rl, rh, cx, cy, 16'(c), 16'(s),
                     cx + offset_near(span), cy + offset_near(span),
                     cx + offset_near(span), cy + offset_near(span)));
        end
      endcase
    end
    @(negedge clk);
    in_tvalid <= 1'b0;
    sending_done = 1'b1;
    while (pending > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

// ===== files.f =====
hw/rtl/srpi_pkg.sv
hw/rtl/srpi_div.sv
hw/rtl/segment_radial_polygon_intersect.sv
hw/rtl/srpi_checker.sv
bench/segment_radial_polygon_intersect_checker.sv
bench/segment_radial_polygon_intersect_tb.sv
